// ===== hw/rtl/rwol_pkg.sv =====
// shared types and constants for the word-order reversal line block
package rwol_pkg;

    localparam logic [7:0] SEPARATOR = 8'h20;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } rwol_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
        logic       line_empty;
        logic       overflowed;
    } rwol_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_END_RD,
        S_END_CHK,
        S_START_RD,
        S_START_CHK,
        S_NEXT_RD,
        S_NEXT_CHK,
        S_SEP,
        S_EMIT_RD,
        S_EMIT_CHK,
        S_EMPTY
    } rwol_state_t;

endpackage

// ===== hw/rtl/rwol_ram.sv =====
// generic single-write, single-read ram with registered read data
module rwol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/reverse_word_order_line.sv =====
// top level: line buffer and sequencer that gives the words of a line in reverse order
// loading: one byte per cycle, s_ready high while no line is being emitted.
// at line end each stored byte is read once on the backward scan and each word byte once more
// when emitted, each read going through a read state and then a check state; output stalls add to this.
// a line with no words gives its single empty result once the backward scan finds no word byte.
// synchronous active-low reset clears the sequencer, fill count and overflow flag; the line
// store is not cleared and holds nothing that is read before it is written.
module reverse_word_order_line #(
    parameter int MAX_LINE = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rwol_pkg::rwol_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rwol_pkg::rwol_out_t m_data
);

    import rwol_pkg::*;

    localparam int AW = $clog2(MAX_LINE);
    localparam int CW = $clog2(MAX_LINE + 1);

    rwol_state_t   state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] pos_reg, pos_next;      // bytes still below the scan point
    logic [AW-1:0] end_reg, end_next;
    logic [AW-1:0] nend_reg, nend_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          more_reg, more_next;
    logic          any_reg, any_next;
    logic          out_valid_reg, out_valid_next;
    rwol_out_t     out_data_reg, out_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          out_free;
    logic          in_fire;
    logic          room;
    logic          word_done;

    rwol_ram #(
        .WIDTH(8),
        .DEPTH(MAX_LINE)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;
    assign room      = (fill_reg < CW'(MAX_LINE));
    assign word_done = (idx_reg == end_reg);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        end_reg      <= end_next;
        nend_reg     <= nend_next;
        idx_reg      <= idx_next;
        more_reg     <= more_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        end_next       = end_reg;
        nend_next      = nend_reg;
        idx_next       = idx_reg;
        more_next      = more_reg;
        any_next       = any_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = fill_reg[AW-1:0];
        ram_wdata      = s_data.in_char;
        ram_re         = 1'b0;
        ram_raddr      = AW'(pos_reg - CW'(1));

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    if (room) begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.in_last) begin
                        pos_next   = room ? fill_reg + CW'(1) : fill_reg;
                        fill_next  = '0;
                        state_next = S_END_RD;
                    end
                end
            end
            // skip trailing spaces to find the end of the last word
            S_END_RD: begin
                if (pos_reg == '0) begin
                    state_next = S_EMPTY;
                end else begin
                    ram_re     = 1'b1;
                    state_next = S_END_CHK;
                end
            end
            S_END_CHK: begin
                pos_next = pos_reg - CW'(1);
                if (ram_rdata == SEPARATOR) begin
                    state_next = S_END_RD;
                end else begin
                    end_next   = AW'(pos_reg - CW'(1));
                    state_next = S_START_RD;
                end
            end
            // walk back to the first byte of the current word
            S_START_RD: begin
                if (pos_reg == '0) begin
                    idx_next   = '0;
                    state_next = S_NEXT_RD;
                end else begin
                    ram_re     = 1'b1;
                    state_next = S_START_CHK;
                end
            end
            S_START_CHK: begin
                pos_next = pos_reg - CW'(1);
                if (ram_rdata == SEPARATOR) begin
                    idx_next   = AW'(pos_reg);
                    state_next = S_NEXT_RD;
                end else begin
                    state_next = S_START_RD;
                end
            end
            // look ahead for a further word so the final byte can be flagged
            S_NEXT_RD: begin
                if (pos_reg == '0) begin
                    more_next  = 1'b0;
                    state_next = any_reg ? S_SEP : S_EMIT_RD;
                end else begin
                    ram_re     = 1'b1;
                    state_next = S_NEXT_CHK;
                end
            end
            S_NEXT_CHK: begin
                pos_next = pos_reg - CW'(1);
                if (ram_rdata == SEPARATOR) begin
                    state_next = S_NEXT_RD;
                end else begin
                    more_next  = 1'b1;
                    nend_next  = AW'(pos_reg - CW'(1));
                    state_next = any_reg ? S_SEP : S_EMIT_RD;
                end
            end
            S_SEP: begin
                if (out_free) begin
                    out_valid_next           = 1'b1;
                    out_data_next.out_char   = SEPARATOR;
                    out_data_next.out_last   = 1'b0;
                    out_data_next.line_empty = 1'b0;
                    out_data_next.overflowed = ovf_reg;
                    state_next               = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = S_EMIT_CHK;
            end
            S_EMIT_CHK: begin
                // read data holds while the output register is still occupied
                if (out_free) begin
                    out_valid_next           = 1'b1;
                    out_data_next.out_char   = ram_rdata;
                    out_data_next.out_last   = word_done && !more_reg;
                    out_data_next.line_empty = 1'b0;
                    out_data_next.overflowed = ovf_reg;
                    any_next                 = 1'b1;
                    if (!word_done) begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_EMIT_RD;
                    end else if (more_reg) begin
                        end_next   = nend_reg;
                        state_next = S_START_RD;
                    end else begin
                        ovf_next   = 1'b0;
                        any_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    out_valid_next           = 1'b1;
                    out_data_next.out_char   = '0;
                    out_data_next.out_last   = 1'b1;
                    out_data_next.line_empty = 1'b1;
                    out_data_next.overflowed = ovf_reg;
                    ovf_next                 = 1'b0;
                    any_next                 = 1'b0;
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // fill count never passes the buffer size
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(MAX_LINE))
        else $error("fill count beyond buffer size");

    // a line-ending transaction stops intake until the line is emitted
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.in_last) |=> !s_ready)
        else $error("input still ready after line end");

    // an empty-line result is always the only and final byte of its line
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.line_empty) |-> (m_data.out_last && m_data.out_char == '0))
        else $error("empty-line result not flagged last");

    // the line store is written only while bytes are loading
    a_no_write_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !ram_we)
        else $error("line store written during emission");

endmodule

// ===== bench/tb_top.sv =====
// testbench for the word-order reversal line block
`timescale 1ns / 100ps

module tb_top;
    import rwol_pkg::*;

    localparam int LINE_DEPTH = 64;
    localparam int TOTAL_BYTES = 210;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 4 * LINE_DEPTH + 8;

    typedef struct {
        rwol_in_t payload;
        bit       wait_drain;
    } line_byte_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    rwol_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rwol_out_t m_data;

    line_byte_t  pending_bytes[$];
    rwol_out_t   expected_bytes[$];
    rwol_out_t   want;

    // shadow copy of the line buffer
    logic [7:0]  line_buf [LINE_DEPTH];
    int          fill_cnt = 0;
    bit          ovf_seen = 1'b0;

    logic        s_took = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    bit          timed_out = 1'b0;
    int unsigned n_queued = 0;

    reverse_word_order_line #(
        .MAX_LINE(LINE_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // store one byte and, on the last byte of a line, queue the reversed words
    function automatic void take_byte(rwol_in_t b);
        rwol_out_t r;
        int pos;
        int wend;
        int wstart;
        int i;
        int n_out;
        if (fill_cnt < LINE_DEPTH) begin
            line_buf[fill_cnt] = b.in_char;
            fill_cnt++;
        end else begin
            ovf_seen = 1'b1;
        end
        if (!b.in_last)
            return;
        n_out = 0;
        pos = fill_cnt - 1;
        while (pos >= 0) begin
            while (pos >= 0 && line_buf[pos] == SEPARATOR)
                pos--;
            if (pos < 0)
                break;
            wend = pos;
            while (pos >= 0 && line_buf[pos] != SEPARATOR)
                pos--;
            wstart = pos + 1;
            if (n_out > 0) begin
                r = '{out_char: SEPARATOR, out_last: 1'b0, line_empty: 1'b0,
                      overflowed: ovf_seen};
                expected_bytes.push_back(r);
                n_out++;
            end
            for (i = wstart; i <= wend; i++) begin
                r = '{out_char: line_buf[i], out_last: 1'b0, line_empty: 1'b0,
                      overflowed: ovf_seen};
                expected_bytes.push_back(r);
                n_out++;
            end
        end
        if (n_out == 0) begin
            r = '{out_char: 8'h00, out_last: 1'b1, line_empty: 1'b1, overflowed: ovf_seen};
            expected_bytes.push_back(r);
        end else begin
            expected_bytes[expected_bytes.size() - 1].out_last = 1'b1;
        end
        fill_cnt = 0;
        ovf_seen = 1'b0;
    endfunction

    function automatic void check_field(string name, int unsigned exp_val,
                                        int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            mismatches++;
        end
    endfunction

    function automatic void push_byte(logic [7:0] ch, bit last, bit drain);
        line_byte_t item;
        item.payload.in_char = ch;
        item.payload.in_last = last;
        item.wait_drain = drain;
        pending_bytes.push_back(item);
        n_queued++;
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == SEPARATOR);
        return c;
    endfunction

    // words of random bytes split by runs of spaces, cut at len bytes
    function automatic void add_word_line(int unsigned len, bit drain);
        logic [7:0]  text[$];
        int unsigned run;
        int unsigned k;
        run = $urandom_range(2);
        while (text.size() < len) begin
            for (k = 0; k < run && text.size() < len; k++)
                text.push_back(SEPARATOR);
            run = $urandom_range(1, 6);
            for (k = 0; k < run && text.size() < len; k++)
                text.push_back(word_char());
            run = $urandom_range(1, 3);
        end
        for (k = 0; k < text.size(); k++)
            push_byte(text[k], k == text.size() - 1, drain && k == 0);
    endfunction

    function automatic void add_noise_line(int unsigned len, bit drain);
        int unsigned k;
        logic [7:0]  ch;
        for (k = 0; k < len; k++) begin
            ch = ($urandom_range(2) == 0) ? SEPARATOR : 8'($urandom_range(255));
            push_byte(ch, k == len - 1, drain && k == 0);
        end
    endfunction

    // driver: next byte may go out on the falling edge after the previous transaction, unless held back
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_took) begin
                if (pending_bytes.size() != 0
                    && (!pending_bytes[0].wait_drain || expected_bytes.size() == 0)
                    && ((bytes_sent >= 60 && bytes_sent < 130)
                        || $urandom_range(99) >= 15)) begin
                    s_data <= pending_bytes[0].payload;
                    s_valid <= 1'b1;
                    void'(pending_bytes.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn
                   && ((results_seen >= 100 && results_seen < 200)
                       || $urandom_range(99) >= 15);
    end

    // monitor: predicts on accepted input, checks accepted results
    always @(posedge aclk) begin
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            take_byte(s_data);
            bytes_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_bytes.size() == 0) begin
                $error("unexpected result: out_char %02h", m_data.out_char);
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                check_field("out_char", 32'(want.out_char), 32'(m_data.out_char));
                check_field("out_last", 32'(want.out_last), 32'(m_data.out_last));
                check_field("line_empty", 32'(want.line_empty), 32'(m_data.line_empty));
                check_field("overflowed", 32'(want.overflowed), 32'(m_data.overflowed));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
            timed_out <= 1'b1;
    end

    initial begin
        int unsigned n_lines;
        int unsigned k;
        bit          drain;

        // separator alone, then single-byte words at the byte extremes
        push_byte(SEPARATOR, 1'b1, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        // leading, repeated and trailing spaces
        push_byte(SEPARATOR, 1'b0, 1'b0);
        push_byte(SEPARATOR, 1'b0, 1'b0);
        push_byte(8'h41, 1'b0, 1'b0);
        push_byte(SEPARATOR, 1'b0, 1'b0);
        push_byte(SEPARATOR, 1'b0, 1'b0);
        push_byte(8'h7E, 1'b0, 1'b0);
        push_byte(SEPARATOR, 1'b1, 1'b0);
        // neighbors of the separator value are word bytes
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(SEPARATOR, 1'b0, 1'b0);
        push_byte(8'h21, 1'b0, 1'b0);
        push_byte(8'h1F, 1'b0, 1'b0);
        push_byte(SEPARATOR, 1'b0, 1'b0);
        push_byte(8'h01, 1'b1, 1'b0);
        // several spaces and no word
        push_byte(SEPARATOR, 1'b0, 1'b0);
        push_byte(SEPARATOR, 1'b0, 1'b0);
        push_byte(SEPARATOR, 1'b1, 1'b0);

        n_lines = 0;
        while (n_queued < TOTAL_BYTES) begin
            drain = (n_lines == 0) || ($urandom_range(7) == 0);
            if (n_lines == 3)
                add_word_line(LINE_DEPTH, drain);
            else if (n_lines == 8)
                add_word_line(LINE_DEPTH + 2, drain);
            else if ($urandom_range(19) == 0)
                add_word_line($urandom_range(LINE_DEPTH - 4, LINE_DEPTH + 8), drain);
            else if ($urandom_range(4) == 0)
                add_noise_line($urandom_range(1, 12), drain);
            else
                add_word_line($urandom_range(1, 14), drain);
            n_lines++;
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while ((pending_bytes.size() != 0 || s_valid || expected_bytes.size() != 0)
               && !timed_out)
            @(posedge aclk);
        for (k = 0; k < TAIL_CYCLES && !timed_out; k++)
            @(posedge aclk);
        if (!timed_out && expected_bytes.size() != 0) begin
            $error("%0d expected results never arrived", expected_bytes.size());
            mismatches++;
        end

        if (!timed_out && mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
